### sv/lqr_balance_drive_mixer_top_defines.svh
// Assertion macros used by the balance drive mixer controller RTL.
`ifndef LQR_BALANCE_DRIVE_MIXER_TOP_DEFINES_SVH
`define LQR_BALANCE_DRIVE_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LBDM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LBDM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lbdm_pkg.sv
// Types and constants shared by the balance drive mixer modules.
package lbdm_pkg;

   localparam int CFG_IDX_W = 3;
   localparam int CFG_DATA_W = 48;

   localparam logic [2:0] MODE_STOP  = 3'd0;
   localparam logic [2:0] MODE_POINT = 3'd1;
   localparam logic [2:0] MODE_EDGE  = 3'd2;
   localparam logic [2:0] MODE_TEST  = 3'd3;
   localparam logic [2:0] MODE_HOLD  = 3'd4;

   localparam logic [CFG_IDX_W-1:0] REG_X_GAINS        = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_Y_GAINS        = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_Z_GAINS        = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_EDGE_GAINS     = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSETS  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_FALL_THRESHOLD = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_SPIN_BIAS      = 3'd7;

   localparam logic [14:0] THRESHOLD_RESET = 15'd2560;
   localparam logic [14:0] LIMIT_RESET     = 15'd2560;

   // Fixed-point constants for the shared multiplier's 18-bit operand, and the test-mode drive
   localparam logic signed [17:0] COS30_Q16  = 18'sd56756;
   localparam logic signed [17:0] THIRD_Q16  = 18'sd21845;
   localparam logic signed [17:0] SEC353_Q14 = 18'sd20074;
   localparam logic signed [15:0] TEST_DRIVE = 16'sd179;

   // Multiply steps, in sequence order: point mode runs OP_VY..OP_YC,
   // edge mode runs OP_EA..OP_ES
   typedef enum logic [3:0] {
      OP_VY, OP_XP, OP_XV, OP_XS, OP_YP, OP_YV, OP_YS, OP_ZV, OP_ZS,
      OP_ZC, OP_YC, OP_EA, OP_EG, OP_EP, OP_EV, OP_ES
   } op_type;

   typedef struct packed {
      logic   load;
      logic   check;
      logic   mul;
      logic   acc;
      logic   emit;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic ok;
   } sts_type;

   typedef struct packed {
      logic [47:0]        x_gains;
      logic [47:0]        y_gains;
      logic [47:0]        z_gains;
      logic [47:0]        edge_gains;
      logic [47:0]        angle_offsets;
      logic [14:0]        fall_threshold;
      logic [14:0]        drive_limit;
      logic signed [15:0] spin_bias;
   } cfg_type;

endpackage

### sv/lbdm_ctrl.sv
// Controller state machine: sequences checks and multiply steps per tick.
`include "lqr_balance_drive_mixer_top_defines.svh"

module lbdm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_mode,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lbdm_pkg::cmd_type cmd,
   input  lbdm_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_MUL, ST_ACC, ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   lbdm_pkg::op_type op_ff, op_in;
   logic [2:0]       mode_ff, mode_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      mode_in   = mode_ff;
      cmd       = '0;
      cmd.op    = op_ff;
      cmd.load  = req_valid && req_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode;
               if (req_mode == lbdm_pkg::MODE_POINT) begin
                  state_in = ST_CHECK;
               end else if (req_mode == lbdm_pkg::MODE_EDGE) begin
                  op_in    = lbdm_pkg::OP_EA;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.ok) begin
               op_in    = (mode_ff == lbdm_pkg::MODE_EDGE) ? lbdm_pkg::OP_EP
                                                           : lbdm_pkg::OP_VY;
               state_in = ST_MUL;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            case (op_ff)
               lbdm_pkg::OP_YC, lbdm_pkg::OP_ES: state_in = ST_EMIT;
               lbdm_pkg::OP_EG:                  state_in = ST_CHECK;
               default: begin
                  op_in    = lbdm_pkg::op_type'(op_ff + 4'd1);
                  state_in = ST_MUL;
               end
            endcase
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= lbdm_pkg::OP_VY;
         mode_ff      <= lbdm_pkg::MODE_STOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `LBDM_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready,
      state_ff != ST_IDLE, "accepted beat did not start work")
   `LBDM_ASSERT_NEXT(a_emit_sets_valid, clock, reset, cmd.emit,
      rsp_valid_ff, "emitted result not presented")
   `LBDM_ASSERT_NEXT(a_mul_then_acc, clock, reset, state_ff == ST_MUL,
      state_ff == ST_ACC && $stable(op_ff), "multiply not followed by accumulate")
   `LBDM_ASSERT_IMPLIES(a_check_balance_mode, clock, reset, state_ff == ST_CHECK,
      mode_ff == lbdm_pkg::MODE_POINT || mode_ff == lbdm_pkg::MODE_EDGE,
      "protection check outside balance modes")

endmodule

### sv/lbdm_datapath.sv
// Datapath: input capture, shared multiplier, LQR sums, mixing and clamp.
module lbdm_datapath #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  lbdm_pkg::cmd_type   cmd,
   output lbdm_pkg::sts_type   sts,
   input  lbdm_pkg::cfg_type   cfg,
   input  logic [2:0]          req_mode,
   input  logic                req_is_static,
   input  logic signed [15:0]  req_pitch_angle,
   input  logic signed [15:0]  req_pitch_rate,
   input  logic signed [15:0]  req_roll_angle,
   input  logic signed [15:0]  req_roll_rate,
   input  logic signed [15:0]  req_yaw_rate,
   input  logic signed [15:0]  req_wheel1_speed,
   input  logic signed [15:0]  req_wheel2_speed,
   input  logic signed [15:0]  req_wheel3_speed,
   output logic signed [15:0]  rsp_drive1,
   output logic signed [15:0]  rsp_drive2,
   output logic signed [15:0]  rsp_drive3,
   output logic                rsp_fallen
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int AW = (SW > 17) ? SW : 17;
   localparam int BW = 18;
   localparam int PW = AW + BW;
   localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

   function automatic logic signed [SW-1:0] sat(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] r;
      begin
         r = v;
         if (v > SAT_HI) r = SAT_HI;
         if (v < SAT_LO) r = SAT_LO;
         return r[SW-1:0];
      end
   endfunction

   function automatic logic signed [PW-1:0] absv(input logic signed [PW-1:0] v);
      return (v < 0) ? -v : v;
   endfunction

   // clamp to +-limit, then negate
   function automatic logic signed [15:0] fin(input logic signed [SW-1:0] d,
                                              input logic signed [PW-1:0] lim);
      logic signed [PW-1:0] v;
      begin
         v = PW'(d);
         if (v >= lim) v = lim;
         if (v <= -lim) v = -lim;
         v = -v;
         return v[15:0];
      end
   endfunction

   // captured beat
   logic [2:0]         mode_ff;
   logic               stat_ff;
   logic signed [15:0] pa_ff, pr_ff, ra_ff, rr_ff, yr_ff, w1_ff, w2_ff, w3_ff;

   // working registers
   logic signed [SW-1:0] vy_ff, ux_ff, uy_ff, uz_ff, zc_ff, yc_ff;
   logic signed [SW-1:0] ang_ff, gyr_ff, edge_ff;
   logic signed [PW-1:0] acc_ff, prod_ff;
   logic                 ok_ff, flag_ff;
   logic signed [15:0]   last_ff [3];
   logic signed [15:0]   drive1_ff, drive2_ff, drive3_ff;
   logic                 fallen_ff;

   logic signed [15:0]   off_x, off_y, off_e;
   logic signed [PW-1:0] ex, ey, ee, thr_w, lim_w, bias_w, diff, sum, r_ext, uxh;
   logic signed [SW-1:0] vx, vz, r;
   logic                 flag_clr, ok_now;
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] prod_w;
   logic [4:0]           sh;
   logic signed [SW-1:0] p0, p1, p2;
   logic signed [15:0]   dn [3];

   assign off_x  = cfg.angle_offsets[15:0];
   assign off_y  = cfg.angle_offsets[31:16];
   assign off_e  = cfg.angle_offsets[47:32];
   assign thr_w  = $signed(PW'(cfg.fall_threshold));
   assign lim_w  = $signed(PW'(cfg.drive_limit));
   assign bias_w = PW'(cfg.spin_bias);

   // exact angle errors for the protection test
   assign ex = PW'(pa_ff) - PW'(off_x);
   assign ey = PW'(ra_ff) - PW'(off_y);
   assign ee = PW'(ang_ff) - PW'(off_e);

   assign flag_clr = stat_ff ? 1'b0 : flag_ff;
   always_comb begin
      if (mode_ff == lbdm_pkg::MODE_EDGE) begin
         ok_now = (absv(ee) < thr_w) && !flag_clr;
      end else begin
         ok_now = (absv(ex) < thr_w) && (absv(ey) < thr_w) && !flag_clr;
      end
   end
   assign sts.ok = ok_now;

   // wheel to axis mixing
   assign vx   = sat(PW'(w2_ff) - (PW'(w3_ff) >>> 1) - (PW'(w1_ff) >>> 1));
   assign vz   = sat(PW'(w1_ff) + PW'(w2_ff) + PW'(w3_ff));
   assign diff = PW'(w3_ff) - PW'(w1_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      sh    = 5'd8;
      case (cmd.op)
         lbdm_pkg::OP_VY: begin
            mul_a = AW'(diff);   mul_b = lbdm_pkg::COS30_Q16;   sh = 5'd16;
         end
         lbdm_pkg::OP_XP: begin mul_a = AW'(sat(ex)); mul_b = BW'($signed(cfg.x_gains[15:0])); end
         lbdm_pkg::OP_XV: begin mul_a = AW'(pr_ff); mul_b = BW'($signed(cfg.x_gains[31:16])); end
         lbdm_pkg::OP_XS: begin mul_a = AW'(vx); mul_b = BW'($signed(cfg.x_gains[47:32])); end
         lbdm_pkg::OP_YP: begin mul_a = AW'(sat(ey)); mul_b = BW'($signed(cfg.y_gains[15:0])); end
         lbdm_pkg::OP_YV: begin mul_a = AW'(rr_ff); mul_b = BW'($signed(cfg.y_gains[31:16])); end
         lbdm_pkg::OP_YS: begin mul_a = AW'(vy_ff); mul_b = BW'($signed(cfg.y_gains[47:32])); end
         lbdm_pkg::OP_ZV: begin mul_a = AW'(yr_ff); mul_b = BW'($signed(cfg.z_gains[31:16])); end
         lbdm_pkg::OP_ZS: begin mul_a = AW'(vz); mul_b = BW'($signed(cfg.z_gains[47:32])); end
         lbdm_pkg::OP_ZC: begin
            mul_a = AW'(uz_ff);  mul_b = lbdm_pkg::THIRD_Q16;   sh = 5'd16;
         end
         lbdm_pkg::OP_YC: begin
            mul_a = AW'(uy_ff);  mul_b = lbdm_pkg::COS30_Q16;   sh = 5'd16;
         end
         lbdm_pkg::OP_EA: begin
            mul_a = AW'(pa_ff);  mul_b = lbdm_pkg::SEC353_Q14;  sh = 5'd14;
         end
         lbdm_pkg::OP_EG: begin
            mul_a = AW'(pr_ff);  mul_b = lbdm_pkg::SEC353_Q14;  sh = 5'd14;
         end
         lbdm_pkg::OP_EP: begin mul_a = AW'(sat(ee)); mul_b = BW'($signed(cfg.edge_gains[15:0])); end
         lbdm_pkg::OP_EV: begin mul_a = AW'(gyr_ff); mul_b = BW'($signed(cfg.edge_gains[31:16])); end
         lbdm_pkg::OP_ES: begin mul_a = AW'(w2_ff); mul_b = BW'($signed(cfg.edge_gains[47:32])); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_w = PW'(mul_a) * PW'(mul_b);
   assign r      = sat(prod_ff >>> sh);
   assign r_ext  = PW'(r);
   assign sum    = acc_ff + r_ext;

   // axis to drive mixing
   assign uxh = PW'(ux_ff) >>> 1;
   assign p0  = sat(-PW'(yc_ff) - uxh + PW'(zc_ff) + bias_w);
   assign p1  = sat(PW'(ux_ff) + PW'(zc_ff) + bias_w);
   assign p2  = sat(-uxh + PW'(yc_ff) + PW'(zc_ff) + bias_w);

   always_comb begin
      dn[0] = '0;
      dn[1] = '0;
      dn[2] = '0;
      case (mode_ff)
         lbdm_pkg::MODE_POINT: begin
            if (ok_ff) begin
               dn[0] = fin(p0, lim_w);
               dn[1] = fin(p1, lim_w);
               dn[2] = fin(p2, lim_w);
            end
         end
         lbdm_pkg::MODE_EDGE: begin
            if (ok_ff) dn[1] = fin(edge_ff, lim_w);
         end
         lbdm_pkg::MODE_TEST: begin
            dn[0] = lbdm_pkg::TEST_DRIVE;
            dn[1] = lbdm_pkg::TEST_DRIVE;
            dn[2] = lbdm_pkg::TEST_DRIVE;
         end
         lbdm_pkg::MODE_HOLD: begin
            dn[0] = last_ff[0];
            dn[1] = last_ff[1];
            dn[2] = last_ff[2];
         end
         default: begin
            dn[0] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         stat_ff <= req_is_static;
         pa_ff   <= req_pitch_angle;
         pr_ff   <= req_pitch_rate;
         ra_ff   <= req_roll_angle;
         rr_ff   <= req_roll_rate;
         yr_ff   <= req_yaw_rate;
         w1_ff   <= req_wheel1_speed;
         w2_ff   <= req_wheel2_speed;
         w3_ff   <= req_wheel3_speed;
      end
      if (cmd.mul) prod_ff <= prod_w;
      if (cmd.check) ok_ff <= ok_now;
      if (cmd.acc) begin
         case (cmd.op)
            lbdm_pkg::OP_VY: vy_ff <= r;
            lbdm_pkg::OP_XP, lbdm_pkg::OP_YP, lbdm_pkg::OP_ZV, lbdm_pkg::OP_EP:
               acc_ff <= r_ext;
            lbdm_pkg::OP_XV, lbdm_pkg::OP_YV, lbdm_pkg::OP_EV: acc_ff <= sum;
            lbdm_pkg::OP_XS: ux_ff   <= sat(sum);
            lbdm_pkg::OP_YS: uy_ff   <= sat(sum);
            lbdm_pkg::OP_ZS: uz_ff   <= sat(sum);
            lbdm_pkg::OP_ZC: zc_ff   <= r;
            lbdm_pkg::OP_YC: yc_ff   <= r;
            lbdm_pkg::OP_EA: ang_ff  <= r;
            lbdm_pkg::OP_EG: gyr_ff  <= r;
            lbdm_pkg::OP_ES: edge_ff <= sat(sum);
            default: acc_ff <= acc_ff;
         endcase
      end
      if (cmd.emit) begin
         drive1_ff <= dn[0];
         drive2_ff <= dn[1];
         drive3_ff <= dn[2];
      end
   end

   // control state: fallen flag and hold memory
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff    <= 1'b1;
         fallen_ff  <= 1'b1;
         last_ff[0] <= '0;
         last_ff[1] <= '0;
         last_ff[2] <= '0;
      end else begin
         if (cmd.check) flag_ff <= !ok_now;
         if (cmd.emit) begin
            fallen_ff  <= flag_ff;
            last_ff[0] <= dn[0];
            last_ff[1] <= dn[1];
            last_ff[2] <= dn[2];
         end
      end
   end

   assign rsp_drive1 = drive1_ff;
   assign rsp_drive2 = drive2_ff;
   assign rsp_drive3 = drive3_ff;
   assign rsp_fallen = fallen_ff;

endmodule

### sv/lqr_balance_drive_mixer_top.sv
// Top level of the LQR balance drive mixer: config registers, control, datapath.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | mode, is_static, attitude, rates, wheels
//  rsp     | out       | rsp_valid/rsp_ready   | drive1..3, fallen
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_wdata
//
// One tick at a time through a single shared multiplier; each product is registered, then accumulated.
// Point mode runs a check plus eleven products; edge mode two products, a check and three more;
// stop, test, hold and spare modes go straight to emit. A new beat is taken while a result waits in rsp.
// Reset is synchronous; it sets the fallen flag and clears the held drives.
// A stalled rsp holds the finished tick in the state machine until the slot frees.
module lqr_balance_drive_mixer_top #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_mode,
   input  logic                  req_is_static,
   input  logic signed [15:0]    req_pitch_angle,
   input  logic signed [15:0]    req_pitch_rate,
   input  logic signed [15:0]    req_roll_angle,
   input  logic signed [15:0]    req_roll_rate,
   input  logic signed [15:0]    req_yaw_rate,
   input  logic signed [15:0]    req_wheel1_speed,
   input  logic signed [15:0]    req_wheel2_speed,
   input  logic signed [15:0]    req_wheel3_speed,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [15:0]    rsp_drive1,
   output logic signed [15:0]    rsp_drive2,
   output logic signed [15:0]    rsp_drive3,
   output logic                  rsp_fallen,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [lbdm_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [lbdm_pkg::CFG_DATA_W-1:0] csr_wdata
);

   lbdm_pkg::cfg_type cfg_ff;
   lbdm_pkg::cmd_type cmd;
   lbdm_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_gains        <= '0;
         cfg_ff.y_gains        <= '0;
         cfg_ff.z_gains        <= '0;
         cfg_ff.edge_gains     <= '0;
         cfg_ff.angle_offsets  <= '0;
         cfg_ff.fall_threshold <= lbdm_pkg::THRESHOLD_RESET;
         cfg_ff.drive_limit    <= lbdm_pkg::LIMIT_RESET;
         cfg_ff.spin_bias      <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lbdm_pkg::REG_X_GAINS:        cfg_ff.x_gains        <= csr_wdata;
            lbdm_pkg::REG_Y_GAINS:        cfg_ff.y_gains        <= csr_wdata;
            lbdm_pkg::REG_Z_GAINS:        cfg_ff.z_gains        <= csr_wdata;
            lbdm_pkg::REG_EDGE_GAINS:     cfg_ff.edge_gains     <= csr_wdata;
            lbdm_pkg::REG_ANGLE_OFFSETS:  cfg_ff.angle_offsets  <= csr_wdata;
            lbdm_pkg::REG_FALL_THRESHOLD: cfg_ff.fall_threshold <= csr_wdata[14:0];
            lbdm_pkg::REG_DRIVE_LIMIT:    cfg_ff.drive_limit    <= csr_wdata[14:0];
            lbdm_pkg::REG_SPIN_BIAS:      cfg_ff.spin_bias      <= csr_wdata[15:0];
            default:                      cfg_ff                <= cfg_ff;
         endcase
      end
   end

   lbdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   lbdm_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg              (cfg_ff),
      .req_mode         (req_mode),
      .req_is_static    (req_is_static),
      .req_pitch_angle  (req_pitch_angle),
      .req_pitch_rate   (req_pitch_rate),
      .req_roll_angle   (req_roll_angle),
      .req_roll_rate    (req_roll_rate),
      .req_yaw_rate     (req_yaw_rate),
      .req_wheel1_speed (req_wheel1_speed),
      .req_wheel2_speed (req_wheel2_speed),
      .req_wheel3_speed (req_wheel3_speed),
      .rsp_drive1       (rsp_drive1),
      .rsp_drive2       (rsp_drive2),
      .rsp_drive3       (rsp_drive3),
      .rsp_fallen       (rsp_fallen)
   );

endmodule

### sim/lqr_balance_drive_mixer_top_test.sv
// Self-checking testbench for the LQR balance drive mixer top level.
`timescale 1ns / 1ps

module lqr_balance_drive_mixer_top_test;

   localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
   localparam logic [2:0] MODE_SPARE_MID = 3'd6;
   localparam logic [2:0] MODE_SPARE     = 3'd7;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES = 8;
   localparam int TICKS_PER_PHASE = 200;

   typedef struct packed {
      logic [2:0]         mode;
      logic               stat;
      logic signed [15:0] pa, pr, ra, rr, yr, w1, w2, w3;
   } tick_type;

   typedef struct packed {
      logic signed [15:0] d1, d2, d3;
      logic               fallen;
   } drives_type;

   typedef struct packed {
      tick_type   tick;
      logic       typed;
      drives_type drives;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic [2:0] req_mode = '0;
   logic req_is_static = 1'b0;
   logic signed [15:0] req_pitch_angle = '0, req_pitch_rate = '0, req_roll_angle = '0;
   logic signed [15:0] req_roll_rate = '0, req_yaw_rate = '0;
   logic signed [15:0] req_wheel1_speed = '0, req_wheel2_speed = '0, req_wheel3_speed = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic signed [15:0] rsp_drive1, rsp_drive2, rsp_drive3;
   logic rsp_fallen;
   logic csr_valid = 1'b0, csr_ready;
   logic [lbdm_pkg::CFG_IDX_W-1:0] csr_index = '0;
   logic [lbdm_pkg::CFG_DATA_W-1:0] csr_wdata = '0;

   lqr_balance_drive_mixer_top dut (.*);

   always #6 clock = ~clock;

   // predictor copy of the registers and state
   logic [47:0] x_gains, y_gains, z_gains, edge_gains, angle_offsets;
   logic [14:0] fall_threshold, drive_limit;
   logic signed [15:0] spin_bias;
   logic fallen_flag;
   longint held_drive [3];

   drives_type drive_queue [$];
   int errors = 0, checked = 0, stall_cycles = 0;
   bit quiet = 0, long_hold_req = 0;

   function automatic longint sat16(longint v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return sat16((a * b) >>> 8);
   endfunction

   function automatic longint gain_of(logic [47:0] packed_val, int k);
      logic signed [15:0] g;
      g = packed_val[16*k +: 16];
      return g;
   endfunction

   function automatic longint lqr_term(longint err, longint rate, longint spd,
                                       logic [47:0] gains);
      return sat16(qmul(err, gain_of(gains, 0)) + qmul(rate, gain_of(gains, 1))
                   + qmul(spd, gain_of(gains, 2)));
   endfunction

   function automatic longint clamp_negate(longint d);
      longint lim;
      lim = drive_limit;
      if (d >= lim) d = lim;
      if (d <= -lim) d = -lim;
      return -d;
   endfunction

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic drives_type mix_drives(tick_type t);
      longint d [3];
      longint ex, ey, vx, vy, vz, ux, uy, uz, zc, yc, ang, gyr, e;
      drives_type r;
      d = '{0, 0, 0};
      case (t.mode)
         lbdm_pkg::MODE_POINT: begin
            ex = longint'(t.pa) - gain_of(angle_offsets, 0);
            ey = longint'(t.ra) - gain_of(angle_offsets, 1);
            if (t.stat) fallen_flag = 1'b0;
            if (abs64(ex) < fall_threshold && abs64(ey) < fall_threshold && !fallen_flag) begin
               vx = sat16(longint'(t.w2) - (longint'(t.w3) >>> 1) - (longint'(t.w1) >>> 1));
               vy = sat16(((longint'(t.w3) - t.w1) * 56756) >>> 16);
               vz = sat16(longint'(t.w1) + t.w2 + t.w3);
               ux = lqr_term(sat16(ex), t.pr, vx, x_gains);
               uy = lqr_term(sat16(ey), t.rr, vy, y_gains);
               uz = lqr_term(0, t.yr, vz, z_gains);
               zc = (uz * 21845) >>> 16;
               yc = (uy * 56756) >>> 16;
               d[0] = sat16(-yc - (ux >>> 1) + zc + spin_bias);
               d[1] = sat16(ux + zc + spin_bias);
               d[2] = sat16(-(ux >>> 1) + yc + zc + spin_bias);
            end else begin
               fallen_flag = 1'b1;
            end
            for (int k = 0; k < 3; k++) d[k] = clamp_negate(d[k]);
         end
         lbdm_pkg::MODE_EDGE: begin
            ang = sat16((longint'(t.pa) * 20074) >>> 14);
            gyr = sat16((longint'(t.pr) * 20074) >>> 14);
            e = ang - gain_of(angle_offsets, 2);
            if (t.stat) fallen_flag = 1'b0;
            if (abs64(e) < fall_threshold && !fallen_flag)
               d[1] = lqr_term(sat16(e), gyr, t.w2, edge_gains);
            else
               fallen_flag = 1'b1;
            d[1] = clamp_negate(d[1]);
         end
         lbdm_pkg::MODE_TEST: d = '{179, 179, 179};
         lbdm_pkg::MODE_HOLD: d = held_drive;
         default: ;
      endcase
      held_drive = d;
      r.d1 = d[0][15:0];
      r.d2 = d[1][15:0];
      r.d3 = d[2][15:0];
      r.fallen = fallen_flag;
      return r;
   endfunction

   // Offer one tick; returns at the accepting edge with valid still high.
   task automatic send_tick(tick_type t, bit typed, drives_type typed_drives);
      drives_type predicted;
      if (!quiet && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_mode, req_is_static, req_pitch_angle, req_pitch_rate, req_roll_angle,
       req_roll_rate, req_yaw_rate, req_wheel1_speed, req_wheel2_speed,
       req_wheel3_speed} <= t;
      do @(posedge clock); while (!req_ready);
      predicted = mix_drives(t);
      drive_queue.push_back(typed ? typed_drives : predicted);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (drive_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [lbdm_pkg::CFG_IDX_W-1:0] idx, logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         lbdm_pkg::REG_X_GAINS:        x_gains = data;
         lbdm_pkg::REG_Y_GAINS:        y_gains = data;
         lbdm_pkg::REG_Z_GAINS:        z_gains = data;
         lbdm_pkg::REG_EDGE_GAINS:     edge_gains = data;
         lbdm_pkg::REG_ANGLE_OFFSETS:  angle_offsets = data;
         lbdm_pkg::REG_FALL_THRESHOLD: fall_threshold = data[14:0];
         lbdm_pkg::REG_DRIVE_LIMIT:    drive_limit = data[14:0];
         lbdm_pkg::REG_SPIN_BIAS:      spin_bias = data[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [15:0] near(int span);
      return 16'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic logic [47:0] moderate_triple(int span);
      return {near(span), near(span), near(span)};
   endfunction

   // Phase 1: positive extremes, phase 2: negative extremes and zero limits,
   // phase 3: fully random registers, rest: moderate working values.
   task automatic configure(int phase);
      logic [47:0] gx, gy, gz, ge, off;
      logic [14:0] thr, lim;
      logic [15:0] bias;
      case (phase)
         1: begin
            gx = {3{16'h7FFF}}; gy = gx; gz = gx; ge = gx; off = {3{16'h7FFF}};
            thr = 15'h7FFF; lim = 15'h7FFF; bias = 16'h7FFF;
         end
         2: begin
            gx = {3{16'h8000}}; gy = gx; gz = gx; ge = gx; off = {3{16'h8000}};
            thr = '0; lim = '0; bias = 16'h8000;
         end
         3: begin
            gx = 48'({$urandom, $urandom}); gy = 48'({$urandom, $urandom});
            gz = 48'({$urandom, $urandom}); ge = 48'({$urandom, $urandom});
            off = 48'({$urandom, $urandom});
            thr = 15'($urandom); lim = 15'($urandom); bias = 16'($urandom);
         end
         default: begin
            gx = moderate_triple(768); gy = moderate_triple(768);
            gz = moderate_triple(768); ge = moderate_triple(768);
            off = moderate_triple(400);
            thr = 15'($urandom_range(1000, 9000));
            lim = 15'($urandom_range(200, 24000));
            bias = near(300);
         end
      endcase
      write_reg(lbdm_pkg::REG_X_GAINS, gx);
      write_reg(lbdm_pkg::REG_Y_GAINS, gy);
      write_reg(lbdm_pkg::REG_Z_GAINS, gz);
      write_reg(lbdm_pkg::REG_EDGE_GAINS, ge);
      write_reg(lbdm_pkg::REG_ANGLE_OFFSETS, off);
      write_reg(lbdm_pkg::REG_FALL_THRESHOLD, {33'd0, thr});
      write_reg(lbdm_pkg::REG_DRIVE_LIMIT, {33'd0, lim});
      write_reg(lbdm_pkg::REG_SPIN_BIAS, {32'd0, bias});
   endtask

   // Mostly balance ticks close to upright so the feedback path runs;
   // the rest is full-range noise and the other modes.
   function automatic tick_type random_tick();
      tick_type t;
      int pick;
      bit wide;
      pick = $urandom_range(0, 99);
      wide = ($urandom_range(0, 4) == 0);
      t.mode = pick < 45 ? lbdm_pkg::MODE_POINT : pick < 70 ? lbdm_pkg::MODE_EDGE :
               pick < 78 ? lbdm_pkg::MODE_TEST : pick < 88 ? lbdm_pkg::MODE_HOLD :
               pick < 95 ? lbdm_pkg::MODE_STOP : 3'($urandom_range(5, 7));
      t.stat = ($urandom_range(0, 9) == 0);
      t.pa = wide ? 16'($urandom) : near(2400);
      t.ra = wide ? 16'($urandom) : near(2400);
      t.pr = wide ? 16'($urandom) : near(4000);
      t.rr = wide ? 16'($urandom) : near(4000);
      t.yr = wide ? 16'($urandom) : near(4000);
      t.w1 = wide ? 16'($urandom) : near(6000);
      t.w2 = wide ? 16'($urandom) : near(6000);
      t.w3 = wide ? 16'($urandom) : near(6000);
      return t;
   endfunction

   localparam drives_type ZERO_UP   = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
   localparam drives_type TEST_UP   = '{16'sd179, 16'sd179, 16'sd179, 1'b1};
   localparam drives_type UNTYPED   = '{16'sd0, 16'sd0, 16'sd0, 1'b0};

   // Directed ticks, run right after reset with reset register values.
   row_type directed [] = '{
      '{'{lbdm_pkg::MODE_STOP, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0}, 1'b1, ZERO_UP},
      '{'{lbdm_pkg::MODE_TEST, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0}, 1'b1, TEST_UP},
      '{'{lbdm_pkg::MODE_HOLD, 1'b1, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5,
          16'sd5, 16'sd5}, 1'b1, TEST_UP},
      '{'{MODE_SPARE, 1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        1'b1, ZERO_UP},
      '{'{MODE_SPARE_LO, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0}, 1'b1, ZERO_UP},
      '{'{MODE_SPARE_MID, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0}, 1'b1, ZERO_UP},
      // still fallen: no static report, so drives stay off
      '{'{lbdm_pkg::MODE_POINT, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0}, 1'b1, ZERO_UP},
      '{'{lbdm_pkg::MODE_EDGE, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0}, 1'b1, ZERO_UP},
      // static clears the flag, angle far out trips it again
      '{'{lbdm_pkg::MODE_POINT, 1'b1, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0}, 1'b1, ZERO_UP},
      '{'{lbdm_pkg::MODE_EDGE, 1'b1, -16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0}, 1'b1, ZERO_UP},
      '{'{lbdm_pkg::MODE_POINT, 1'b1, 16'sd2559, 16'sd0, -16'sd2559, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0}, 1'b0, UNTYPED},
      '{'{lbdm_pkg::MODE_POINT, 1'b0, 16'sd2560, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0}, 1'b1, ZERO_UP},
      '{'{lbdm_pkg::MODE_EDGE, 1'b1, 16'sd2000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sh7FFF, 16'sd0}, 1'b0, UNTYPED},
      '{'{lbdm_pkg::MODE_HOLD, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0}, 1'b0, UNTYPED},
      '{'{lbdm_pkg::MODE_POINT, 1'b1, 16'sd0, -16'sh8000, 16'sd0, 16'sh7FFF, -16'sh8000,
          16'sh7FFF, -16'sh8000, 16'sh7FFF}, 1'b0, UNTYPED},
      '{'{lbdm_pkg::MODE_POINT, 1'b0, 16'sd0, 16'sh7FFF, 16'sd0, -16'sh8000, 16'sh7FFF,
          -16'sh8000, 16'sh7FFF, -16'sh8000}, 1'b0, UNTYPED},
      '{'{lbdm_pkg::MODE_EDGE, 1'b0, -16'sd100, -16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          -16'sh8000, 16'sd0}, 1'b0, UNTYPED},
      '{'{lbdm_pkg::MODE_HOLD, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0}, 1'b0, UNTYPED}
   };

   // result receiver with random stalls and one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 0;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && !reset && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      drives_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_queue.size() == 0) begin
            $display("%0t: result beat with nothing expected: %0d %0d %0d fallen %0b",
                     $time, rsp_drive1, rsp_drive2, rsp_drive3, rsp_fallen);
            errors++;
         end else begin
            want = drive_queue.pop_front();
            checked++;
            if (rsp_drive1 !== want.d1) begin
               $display("%0t: drive1 expected %0d actual %0d", $time, want.d1, rsp_drive1);
               errors++;
            end
            if (rsp_drive2 !== want.d2) begin
               $display("%0t: drive2 expected %0d actual %0d", $time, want.d2, rsp_drive2);
               errors++;
            end
            if (rsp_drive3 !== want.d3) begin
               $display("%0t: drive3 expected %0d actual %0d", $time, want.d3, rsp_drive3);
               errors++;
            end
            if (rsp_fallen !== want.fallen) begin
               $display("%0t: fallen expected %0b actual %0b", $time, want.fallen, rsp_fallen);
               errors++;
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      x_gains = '0; y_gains = '0; z_gains = '0; edge_gains = '0; angle_offsets = '0;
      fall_threshold = lbdm_pkg::THRESHOLD_RESET;
      drive_limit = lbdm_pkg::LIMIT_RESET;
      spin_bias = '0;
      fallen_flag = 1'b1;
      held_drive = '{0, 0, 0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      foreach (directed[i])
         send_tick(directed[i].tick, directed[i].typed, directed[i].drives);
      drain();

      for (int p = 1; p <= PHASES; p++) begin
         configure(p);
         if (p == PHASES) quiet = 1;
         // fill the block while results are held back
         if (p == 4) begin
            long_hold_req = 1;
            for (int i = 0; i < 20; i++) send_tick(random_tick(), 1'b0, UNTYPED);
         end
         for (int i = 0; i < TICKS_PER_PHASE; i++) send_tick(random_tick(), 1'b0, UNTYPED);
         drain();
      end

      $display("Ran %0d ticks over reset, extreme and random register settings in all modes.",
               checked);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/lbdm_pkg.sv
sv/lbdm_ctrl.sv
sv/lbdm_datapath.sv
sv/lqr_balance_drive_mixer_top.sv
sim/lqr_balance_drive_mixer_top_test.sv
